// ===== src/imsf_pkg.sv =====
// shared types, constants and helpers for the ising metropolis spin-flip block
// no dependencies; imported by every module of the block

package imsf_pkg;

  localparam int LATTICE_SIDE = 16;
  localparam int COORD_W      = $clog2(LATTICE_SIDE);
  localparam int ROW_COUNT    = LATTICE_SIDE * LATTICE_SIDE;
  localparam int ROW_W        = $clog2(ROW_COUNT);
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;

  localparam int IN_COORD_W = 4;
  localparam int IN_COORDS  = 2 ** IN_COORD_W;
  localparam int FRAC_W     = 16;
  localparam int DE_W       = 5;
  localparam int ENERGY_W   = 15;
  localparam int MAG_W      = 14;

  localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-3 * SITE_COUNT);
  localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITE_COUNT);

  // threshold register indexes; the last one names no register
  typedef enum logic [1:0] {
    REG_THR4   = 2'd0,
    REG_THR8   = 2'd1,
    REG_THR12  = 2'd2,
    REG_UNUSED = 2'd3
  } cfg_reg_e;

  typedef logic [COORD_W-1:0] coord_tab_t [IN_COORDS];

  function automatic coord_tab_t build_coord_tab();
    coord_tab_t tab;
    for (int i = 0; i < IN_COORDS; i++) begin
      tab[i] = COORD_W'(i % LATTICE_SIDE);
    end
    return tab;
  endfunction

  // input coordinate reduced modulo the lattice side
  localparam coord_tab_t COORD_MOD = build_coord_tab();

  function automatic logic [COORD_W-1:0] step_up(input logic [COORD_W-1:0] c);
    return (c == COORD_W'(LATTICE_SIDE - 1)) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [COORD_W-1:0] step_down(input logic [COORD_W-1:0] c);
    return (c == '0) ? COORD_W'(LATTICE_SIDE - 1) : c - 1'b1;
  endfunction

  // a lattice row holds all z positions of one (x, y) pair
  function automatic logic [ROW_W-1:0] row_of(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
    return ROW_W'(x) * ROW_W'(LATTICE_SIDE) + ROW_W'(y);
  endfunction

  typedef struct packed {
    logic [ROW_W-1:0]   row_c;
    logic [ROW_W-1:0]   row_xp;
    logic [ROW_W-1:0]   row_xm;
    logic [ROW_W-1:0]   row_yp;
    logic [ROW_W-1:0]   row_ym;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] zp;
    logic [COORD_W-1:0] zm;
    logic [FRAC_W-1:0]  rnd;
  } trial_t;

  typedef struct packed {
    logic [FRAC_W-1:0] thr4;
    logic [FRAC_W-1:0] thr8;
    logic [FRAC_W-1:0] thr12;
  } thr_t;

endpackage

// ===== src/imsf_front.sv =====
// front end: takes trial requests, reduces coordinates and forms neighbor rows
// depends on imsf_pkg

module imsf_front import imsf_pkg::*; (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [IN_COORD_W-1:0] site_x_i,
  input  logic [IN_COORD_W-1:0] site_y_i,
  input  logic [IN_COORD_W-1:0] site_z_i,
  input  logic [FRAC_W-1:0]     random_fraction_i,
  input  logic                  full_i,
  input  logic                  block_i,
  output logic                  push_o,
  output trial_t                push_data_o
);

  logic [COORD_W-1:0] x, y, z;

  assign x = COORD_MOD[site_x_i];
  assign y = COORD_MOD[site_y_i];
  assign z = COORD_MOD[site_z_i];

  assign in_stall_o = full_i | block_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    push_data_o.row_c  = row_of(x, y);
    push_data_o.row_xp = row_of(step_up(x), y);
    push_data_o.row_xm = row_of(step_down(x), y);
    push_data_o.row_yp = row_of(x, step_up(y));
    push_data_o.row_ym = row_of(x, step_down(y));
    push_data_o.z      = z;
    push_data_o.zp     = step_up(z);
    push_data_o.zm     = step_down(z);
    push_data_o.rnd    = random_fraction_i;
  end

endmodule

// ===== src/imsf_queue.sv =====
// two-entry queue of trials between front and back end
// depends on imsf_pkg

module imsf_queue import imsf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  trial_t data_i,
  output logic   full_o,
  output logic   valid_o,
  output trial_t data_o,
  input  logic   pop_i
);

  localparam int Depth = 2;

  trial_t           entry_q [Depth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== src/imsf_back.sv =====
// back end: lattice memory, metropolis decision, running sums, result register
// depends on imsf_pkg

module imsf_back import imsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  trial_t                q_data_i,
  output logic                  pop_o,
  input  thr_t                  thr_i,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  flipped_o,
  output logic [DE_W-1:0]       delta_energy_o,
  output logic [ENERGY_W-1:0]   total_energy_o,
  output logic [MAG_W-1:0]      total_magnetization_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e state_q;

  // three copies of the lattice, same writes, so five rows can be read at once
  logic [LATTICE_SIDE-1:0] mem_a [ROW_COUNT];
  logic [LATTICE_SIDE-1:0] mem_b [ROW_COUNT];
  logic [LATTICE_SIDE-1:0] mem_c [ROW_COUNT];

  logic [LATTICE_SIDE-1:0] rd_c_q, rd_xp_q, rd_xm_q, rd_yp_q, rd_ym_q;
  trial_t                  cur_q;
  logic [ROW_W-1:0]        clr_cnt_q;
  logic [ENERGY_W-1:0]     energy_q;
  logic [MAG_W-1:0]        mag_q;
  logic                    out_valid_q, flipped_q;
  logic                    out_valid_d;
  logic [DE_W-1:0]         de_q;

  logic                    rd_en, commit, mem_we;
  logic [ROW_W-1:0]        w_addr;
  logic [LATTICE_SIDE-1:0] w_data;
  logic                    s_down;
  logic [2:0]              down_cnt;
  logic [DE_W-1:0]         base, de;
  logic [FRAC_W-1:0]       thr;
  logic                    flip;

  assign rd_en  = (state_q == ST_IDLE) && q_valid_i;
  assign pop_o  = rd_en;
  assign commit = (state_q == ST_EVAL) && (!out_valid_q || !out_stall_i);
  assign busy_o = (state_q == ST_CLEAR);

  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  // bit set means spin down
  assign s_down   = rd_c_q[cur_q.z];
  assign down_cnt = 3'(rd_xp_q[cur_q.z]) + 3'(rd_xm_q[cur_q.z]) + 3'(rd_yp_q[cur_q.z])
                  + 3'(rd_ym_q[cur_q.z]) + 3'(rd_c_q[cur_q.zp]) + 3'(rd_c_q[cur_q.zm]);

  // neighbor sum is 6 - 2*down, so 2*sum = 12 - 4*down, wraps into 5 bits
  assign base = DE_W'(12) - {down_cnt, 2'b00};
  assign de   = s_down ? (DE_W'(0) - base) : base;

  always_comb begin
    if (de == DE_W'(4)) begin
      thr = thr_i.thr4;
    end else if (de == DE_W'(8)) begin
      thr = thr_i.thr8;
    end else begin
      thr = thr_i.thr12;
    end
  end

  assign flip = de[DE_W-1] || (de == '0) || (cur_q.rnd <= thr);

  assign mem_we = busy_o || (commit && flip);
  assign w_addr = busy_o ? clr_cnt_q : cur_q.row_c;
  assign w_data = busy_o ? '0 : (rd_c_q ^ (LATTICE_SIDE'(1) << cur_q.z));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_a[w_addr] <= w_data;
      mem_b[w_addr] <= w_data;
      mem_c[w_addr] <= w_data;
    end
    if (rd_en) begin
      rd_c_q  <= mem_a[q_data_i.row_c];
      rd_xp_q <= mem_a[q_data_i.row_xp];
      rd_xm_q <= mem_b[q_data_i.row_xm];
      rd_yp_q <= mem_b[q_data_i.row_yp];
      rd_ym_q <= mem_c[q_data_i.row_ym];
      cur_q   <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      energy_q    <= ENERGY_RESET;
      mag_q       <= MAG_RESET;
      out_valid_q <= 1'b0;
      flipped_q   <= 1'b0;
      de_q        <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ROW_W'(ROW_COUNT - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (rd_en) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (commit) begin
            flipped_q   <= flip;
            de_q        <= de;
            if (flip) begin
              energy_q <= energy_q + ENERGY_W'(signed'(de));
              mag_q    <= s_down ? mag_q + MAG_W'(2) : mag_q - MAG_W'(2);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o           = out_valid_q;
  assign flipped_o             = flipped_q;
  assign delta_energy_o        = de_q;
  assign total_energy_o        = energy_q;
  assign total_magnetization_o = mag_q;

endmodule

// ===== src/ising_metropolis_spin_flip_top.sv =====
// top level of the ising metropolis spin-flip block: threshold registers and wiring
// depends on imsf_pkg, imsf_front, imsf_queue, imsf_back

// Metropolis single-spin trials on a periodic 16x16x16 lattice of one-bit spins.
// Each request names a site and carries a 16-bit random fraction; each yields one
// result with the flip decision, dE and the running energy and magnetization.
// In the back end a trial's five lattice rows are read in the idle state, then the
// eval state decides and writes the site row back, waiting while a held result is
// stalled; the next trial is read only after the last one commits, and a two-entry
// queue lets requests arrive while a trial is in flight. After reset the lattice
// memory is swept to all spins up, one row per cycle, over all 256 rows; requests
// are stalled during that sweep, while threshold writes are accepted at any time.

module ising_metropolis_spin_flip_top import imsf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [FRAC_W-1:0]          cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [IN_COORD_W-1:0]      site_x_i,
  input  logic [IN_COORD_W-1:0]      site_y_i,
  input  logic [IN_COORD_W-1:0]      site_z_i,
  input  logic [FRAC_W-1:0]          random_fraction_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       flipped_o,
  output logic signed [DE_W-1:0]     delta_energy_o,
  output logic signed [ENERGY_W-1:0] total_energy_o,
  output logic signed [MAG_W-1:0]    total_magnetization_o
);

  thr_t   thr_q;
  logic   push, full, q_valid, pop, busy;
  trial_t push_data, q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_THR4:  thr_q.thr4  <= cfg_data_i;
        REG_THR8:  thr_q.thr8  <= cfg_data_i;
        REG_THR12: thr_q.thr12 <= cfg_data_i;
        default:   thr_q       <= thr_q;
      endcase
    end
  end

  imsf_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .site_x_i          (site_x_i),
    .site_y_i          (site_y_i),
    .site_z_i          (site_z_i),
    .random_fraction_i (random_fraction_i),
    .full_i            (full),
    .block_i           (busy),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  imsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  imsf_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .q_valid_i             (q_valid),
    .q_data_i              (q_data),
    .pop_o                 (pop),
    .thr_i                 (thr_q),
    .busy_o                (busy),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .flipped_o             (flipped_o),
    .delta_energy_o        (delta_energy_o),
    .total_energy_o        (total_energy_o),
    .total_magnetization_o (total_magnetization_o)
  );

  // a rejected trial always had an uphill move
  a_reject_uphill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !flipped_o |-> delta_energy_o > 0)
    else $error("rejected trial with non-positive dE");

  // dE is always a multiple of four
  a_de_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> delta_energy_o[1:0] == 2'b00)
    else $error("dE not a multiple of four");

  // nothing enters or leaves while the lattice sweep runs
  a_sweep_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !out_valid_o && !q_valid)
    else $error("activity during lattice sweep");

endmodule
